// ===== rtl/core/grs_pkg.sv =====
// ----------------------------------------------------------------------------
// grs_pkg
// Shared types and constants for the group reversing stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package grs_pkg;

    localparam int unsigned GRS_DATA_W = 32;
    localparam int unsigned GRS_CFG_W  = 7;

    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } grs_state_t;

    typedef struct packed {
        logic wr;
        logic close;
        logic rd;
    } grs_cmd_t;

    typedef struct packed {
        logic close_now;
        logic rd_ok;
        logic rd_last;
    } grs_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/grs_ctrl.sv =====
// ----------------------------------------------------------------------------
// grs_ctrl
// Sequencer: collects beats into the group store, then issues reversed reads.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_ctrl
    import grs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire grs_status_t status,
    output grs_cmd_t         cmd
);

    grs_state_t state_reg;
    grs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        unique case (state_reg)
            ST_FILL:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.wr = 1'b1;
                    if (status.close_now)
                    begin
                        cmd.close  = 1'b1;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (status.rd_ok)
                begin
                    cmd.rd = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/grs_datapath.sv =====
// ----------------------------------------------------------------------------
// grs_datapath
// Group store, fill and read pointers, size register and output pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_datapath
    import grs_pkg::*;
#(
    parameter int unsigned MAX_GROUP = 64
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr,
    input  wire logic [GRS_CFG_W-1:0]         cfg_group_size,
    input  wire logic signed [GRS_DATA_W-1:0] value,
    input  wire logic                         seq_end,
    input  wire grs_cmd_t                     cmd,
    output grs_status_t                       status,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [GRS_DATA_W-1:0]      out_value,
    output logic                              group_last,
    output logic                              seq_last
);

    localparam int unsigned AW = $clog2(MAX_GROUP);
    localparam int unsigned EW = (AW + 1 > GRS_CFG_W) ? AW + 1 : GRS_CFG_W;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_GROUP);

    logic [GRS_DATA_W-1:0] mem [MAX_GROUP];

    logic [GRS_CFG_W-1:0]  size_reg;
    logic [AW-1:0]         fill_reg;
    logic [AW-1:0]         rd_ptr_reg;
    logic                  end_reg;

    logic                  s1_valid_reg;
    logic [GRS_DATA_W-1:0] s1_data_reg;
    logic                  s1_glast_reg;
    logic                  s1_slast_reg;

    logic                  o_valid_reg;
    logic [GRS_DATA_W-1:0] o_data_reg;
    logic                  o_glast_reg;
    logic                  o_slast_reg;

    logic [EW-1:0]         size_e;
    logic [EW-1:0]         eff_size;
    logic [EW-1:0]         fill_inc;
    logic                  o_free;
    logic                  s1_move;

    always_comb
    begin
        size_e = EW'(size_reg);
        priority if (size_e == '0)
        begin
            eff_size = EW'(1);
        end
        else if (size_e > MAX_E)
        begin
            eff_size = MAX_E;
        end
        else
        begin
            eff_size = size_e;
        end
        fill_inc = EW'(fill_reg) + EW'(1);
    end

    assign o_free  = !o_valid_reg || !out_stall;
    assign s1_move = s1_valid_reg && o_free;

    assign status.close_now = (fill_inc >= eff_size) || seq_end;
    assign status.rd_ok     = !s1_valid_reg || o_free;
    assign status.rd_last   = (rd_ptr_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[fill_reg] <= value;
        end
        if (cmd.rd)
        begin
            s1_data_reg  <= mem[rd_ptr_reg];
            s1_glast_reg <= (rd_ptr_reg == '0);
            s1_slast_reg <= (rd_ptr_reg == '0) && end_reg;
        end
        if (s1_move)
        begin
            o_data_reg  <= s1_data_reg;
            o_glast_reg <= s1_glast_reg;
            o_slast_reg <= s1_slast_reg;
        end
        if (cmd.close)
        begin
            rd_ptr_reg <= fill_reg;
            end_reg    <= seq_end;
        end
        else if (cmd.rd)
        begin
            rd_ptr_reg <= rd_ptr_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= GRS_CFG_W'(1);
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                size_reg <= cfg_group_size;
            end
            if (cmd.close)
            begin
                fill_reg <= '0;
            end
            else if (cmd.wr)
            begin
                fill_reg <= fill_reg + AW'(1);
            end
            if (cmd.rd)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (o_free)
            begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_value  = o_data_reg;
    assign group_last = o_glast_reg;
    assign seq_last   = o_slast_reg;

endmodule

`default_nettype wire

// ===== rtl/core/group_reverse_stream.sv =====
// ----------------------------------------------------------------------------
// group_reverse_stream
// Reverses a stream of signed words in groups of a programmable size.
//
//   channel   direction   handshake             payload
//   cfg       in          cfg_valid/cfg_ready   cfg_group_size
//   in        in          in_valid/in_stall     value, seq_end
//   out       out         out_valid/out_stall   out_value, group_last, seq_last
//
// Input beats are taken one per cycle while a group fills. The beat that
// closes a group stalls the input until the whole group has been read
// back: the single read port of the group store gives one word a cycle
// while the output is not stalled. Output stalls hold the two-deep output
// pipeline (read register, then output register) and pause the reads.
// Reset clears control state; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module group_reverse_stream
    import grs_pkg::*;
#(
    parameter int unsigned MAX_GROUP = 64
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [GRS_CFG_W-1:0]         cfg_group_size,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [GRS_DATA_W-1:0] value,
    input  wire logic                         seq_end,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [GRS_DATA_W-1:0]      out_value,
    output logic                              group_last,
    output logic                              seq_last
);

    grs_cmd_t    cmd;
    grs_status_t status;

    assign cfg_ready = 1'b1;

    grs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    grs_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_group_size (cfg_group_size),
        .value          (value),
        .seq_end        (seq_end),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_value      (out_value),
        .group_last     (group_last),
        .seq_last       (seq_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/grs_checker.sv =====
// ----------------------------------------------------------------------------
// grs_checker
// Port-level checks for the group reversing stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_checker
    import grs_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  seq_end,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [GRS_DATA_W-1:0] out_value,
    input wire logic                  group_last,
    input wire logic                  seq_last
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_value)
            && $stable(group_last) && $stable(seq_last))
        else $error("stalled output beat changed");

    a_seq_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seq_last |-> group_last)
        else $error("sequence end without group end");

    a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && seq_end |=> in_stall)
        else $error("input taken after sequence end beat");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output beat straight out of reset");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .seq_end    (seq_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .group_last (group_last),
    .seq_last   (seq_last)
);

`default_nettype wire
